FILE: src/rc4_stream_cipher_top_defines.svh
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top_defines
// Assertion macros shared by the RC4 block.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RC4_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RC4_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Types and constants of the RC4 stream cipher block.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int PERM_DEPTH        = 256;
    localparam int LEN_W             = 4;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 8;
    localparam int DEF_MAX_KEY_BYTES = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = CFG_IDX_W'(1);

    localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = LEN_W'(8);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KRD_I,
        ST_KRD_J,
        ST_KWR_I,
        ST_KWR_J,
        ST_GRD_I,
        ST_GRD_J,
        ST_GWR_I,
        ST_GWR_J
    } rc4_state_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rc4_result_t;

endpackage

FILE: src/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/rc4_core.sv
// ----------------------------------------------------------------------------
// rc4_core
// Sequencer for key schedule and keystream generation over the permutation RAM.
// ----------------------------------------------------------------------------
module rc4_core import rc4_pkg::*; #(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [MAX_KEY_BYTES*BYTE_W-1:0] key_i,
    input  logic [LEN_W-1:0]                key_len_i,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [BYTE_W-1:0]               s_data_byte,
    input  logic                            s_first_of_message,
    input  logic                            out_free_i,
    output rc4_result_t                     res_o
);

    localparam int KPW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [BYTE_W-1:0] LAST_N = BYTE_W'(PERM_DEPTH - 1);

    rc4_state_t state_reg, state_next;

    logic [BYTE_W-1:0] idx_i_reg, idx_i_next;
    logic [BYTE_W-1:0] idx_j_reg, idx_j_next;
    logic              keyed_reg, keyed_next;
    logic [BYTE_W-1:0] n_reg, n_next;
    logic [KPW-1:0]    kpos_reg, kpos_next;
    logic [BYTE_W-1:0] kj_reg, kj_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic              fwd_reg, fwd_next;
    logic [BYTE_W-1:0] fwd_val_reg, fwd_val_next;
    logic [BYTE_W-1:0] data_reg, data_next;

    logic              ram_we;
    logic [BYTE_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic [BYTE_W-1:0] key_arr [MAX_KEY_BYTES];
    logic [BYTE_W-1:0] key_byte;
    logic              kpos_last;
    logic              accept;
    logic              need_ks;
    logic [BYTE_W-1:0] i_inc;
    logic [BYTE_W-1:0] si_gen;
    logic [BYTE_W-1:0] kj_sum;
    logic [BYTE_W-1:0] t_gen;
    logic [BYTE_W-1:0] ks;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        for (int k = 0; k < MAX_KEY_BYTES; k++) begin
            key_arr[k] = key_i[k*BYTE_W +: BYTE_W];
        end
    end

    assign key_byte  = key_arr[kpos_reg];
    assign kpos_last = (LEN_W'(kpos_reg) == (key_len_i - LEN_W'(1)));
    assign s_ready   = (state_reg == ST_IDLE) || ((state_reg == ST_GWR_J) && out_free_i);
    assign accept    = s_valid && s_ready;
    assign need_ks   = s_first_of_message || !keyed_reg;
    assign i_inc     = idx_i_reg + BYTE_W'(1);
    assign si_gen    = fwd_reg ? fwd_val_reg : ram_rdata;
    assign kj_sum    = kj_reg + ram_rdata + key_byte;
    assign t_gen     = si_reg + sj_reg;

    always_comb begin
        priority if (t_gen == idx_j_reg) begin
            ks = si_reg;
        end else if (t_gen == idx_i_reg) begin
            ks = sj_reg;
        end else begin
            ks = ram_rdata;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = need_ks ? ST_FILL : ST_GRD_J;
                end
            end
            ST_FILL:  state_next = (n_reg == LAST_N) ? ST_KRD_I : ST_FILL;
            ST_KRD_I: state_next = ST_KRD_J;
            ST_KRD_J: state_next = ST_KWR_I;
            ST_KWR_I: state_next = ST_KWR_J;
            ST_KWR_J: state_next = (n_reg == LAST_N) ? ST_GRD_I : ST_KRD_I;
            ST_GRD_I: state_next = ST_GRD_J;
            ST_GRD_J: state_next = ST_GWR_I;
            ST_GWR_I: state_next = ST_GWR_J;
            ST_GWR_J: begin
                if (out_free_i) begin
                    if (s_valid) begin
                        state_next = need_ks ? ST_FILL : ST_GRD_J;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idx_i_next   = idx_i_reg;
        idx_j_next   = idx_j_reg;
        keyed_next   = keyed_reg;
        n_next       = n_reg;
        kpos_next    = kpos_reg;
        kj_next      = kj_reg;
        si_next      = si_reg;
        sj_next      = sj_reg;
        fwd_next     = fwd_reg;
        fwd_val_next = fwd_val_reg;
        data_next    = data_reg;
        ram_we       = 1'b0;
        ram_waddr    = n_reg;
        ram_wdata    = n_reg;
        ram_re       = 1'b0;
        ram_raddr    = n_reg;
        res_o.valid  = 1'b0;
        res_o.data   = data_reg ^ ks;

        if (accept) begin
            data_next = s_data_byte;
            if (need_ks) begin
                n_next    = '0;
                kpos_next = '0;
                kj_next   = '0;
            end else begin
                ram_re       = 1'b1;
                ram_raddr    = i_inc;
                idx_i_next   = i_inc;
                fwd_next     = (state_reg == ST_GWR_J) && (i_inc == idx_j_reg);
                fwd_val_next = si_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_FILL: begin
                ram_we = 1'b1;
                n_next = n_reg + BYTE_W'(1);
            end
            ST_KRD_I: begin
                ram_re = 1'b1;
            end
            ST_KRD_J: begin
                si_next   = ram_rdata;
                kj_next   = kj_sum;
                ram_re    = 1'b1;
                ram_raddr = kj_sum;
            end
            ST_KWR_I: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_KWR_J: begin
                ram_we    = 1'b1;
                ram_waddr = kj_reg;
                ram_wdata = si_reg;
                n_next    = n_reg + BYTE_W'(1);
                kpos_next = kpos_last ? '0 : kpos_reg + KPW'(1);
                if (n_reg == LAST_N) begin
                    keyed_next = 1'b1;
                    idx_i_next = '0;
                    idx_j_next = '0;
                end
            end
            ST_GRD_I: begin
                ram_re     = 1'b1;
                ram_raddr  = i_inc;
                idx_i_next = i_inc;
                fwd_next   = 1'b0;
            end
            ST_GRD_J: begin
                si_next    = si_gen;
                idx_j_next = idx_j_reg + si_gen;
                ram_re     = 1'b1;
                ram_raddr  = idx_j_reg + si_gen;
            end
            ST_GWR_I: begin
                sj_next   = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = idx_i_reg;
                ram_wdata = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = si_reg + ram_rdata;
            end
            ST_GWR_J: begin
                ram_we      = 1'b1;
                ram_waddr   = idx_j_reg;
                ram_wdata   = si_reg;
                res_o.valid = out_free_i;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            keyed_reg <= 1'b0;
            idx_i_reg <= '0;
            idx_j_reg <= '0;
            fwd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            keyed_reg <= keyed_next;
            idx_i_reg <= idx_i_next;
            idx_j_reg <= idx_j_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        kpos_reg    <= kpos_next;
        kj_reg      <= kj_next;
        si_reg      <= si_next;
        sj_reg      <= sj_next;
        fwd_val_reg <= fwd_val_next;
        data_reg    <= data_next;
    end

endmodule

FILE: src/rc4_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// Flow: a byte reads S[i] on accept, S[j] in GRD_J, S[t] in GWR_I; rekeying runs FILL and the key
// schedule first. Three reads, two writes per byte; a byte is taken only in IDLE or a free GWR_J.
// Reset: synchronous active-low aresetn clears control, indices and keyed flag; key to 0, length 8.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_top_defines.svh"

module rc4_stream_cipher_top import rc4_pkg::*; #(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_byte,
    input  logic                  s_first_of_message,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_result_byte
);

    localparam int KEY_W = MAX_KEY_BYTES * BYTE_W;

    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  key_len_reg;
    logic [LEN_W-1:0]  key_len_eff;
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;
    logic              out_free;
    rc4_result_t       res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            key_len_reg <= KEY_LENGTH_RESET;
        end else if (cfg_valid) begin
            priority if (cfg_index == REG_KEY_BYTES) begin
                key_reg <= cfg_data[KEY_W-1:0];
            end else if (cfg_index == REG_KEY_LENGTH) begin
                key_len_reg <= cfg_data[LEN_W-1:0];
            end else begin
            end
        end
    end

    always_comb begin
        priority if (key_len_reg == '0) begin
            key_len_eff = LEN_W'(1);
        end else if (key_len_reg > LEN_W'(MAX_KEY_BYTES)) begin
            key_len_eff = LEN_W'(MAX_KEY_BYTES);
        end else begin
            key_len_eff = key_len_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    rc4_core #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .key_i              (key_reg),
        .key_len_i          (key_len_eff),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_first_of_message (s_first_of_message),
        .out_free_i         (out_free),
        .res_o              (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_data_reg <= res.data;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_byte = m_data_reg;

    `RC4_ASSERT_NOW(a_res_into_free_slot, aclk, aresetn, res.valid, out_free, "slot busy")
    `RC4_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_valid && s_ready, !res.valid, "early")
    `RC4_ASSERT_NEXT(a_result_spacing, aclk, aresetn, res.valid, !res.valid, "adjacent results")

endmodule
